@@ rtl/bsf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsf_pkg
// Shared types and constants of the binomial smoothing filter.
// ----------------------------------------------------------------------------
package bsf_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int VALUE_W    = 48;
  localparam int PASS_W     = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_PASS_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_MODE = 4'd1;

  localparam logic [PASS_W-1:0] PASS_COUNT_RST = 4'd1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last_value;
  } out_word_t;

  // control half of a word moving along the cell row
  typedef struct packed {
    logic valid;
    logic last;
  } tok_ctl_t;

  typedef enum logic [3:0] {
    DV_IDLE = 4'b0001,
    DV_RUN  = 4'b0010,
    DV_FIN  = 4'b0100,
    DV_DONE = 4'b1000
  } div_state_t;

endpackage

@@ rtl/binomial_smoothing_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binomial_smoothing_filter
// Iterated 1-2-1 smoothing over vectors of signed samples, one cell per pass.
// ----------------------------------------------------------------------------
// Low-pass mode: one word per cycle in steady state while the output does not
//   stall; with samples back to back a word passes the input register, each
//   cell (which waits for the right-hand neighbor) and the output register.
// Low-pass mode: input holds off after a vector's last sample while the
//   vector flushes.
// Ratio mode: the serial divider sets the rate; input waits until it is idle again.
// Reset: pass_count 1, low-pass mode, all cells and queues empty.
module binomial_smoothing_filter #(
  parameter int MAX_PASSES    = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  bsf_pkg::in_word_t                    in_word,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output bsf_pkg::out_word_t                   out_word,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bsf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bsf_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int DW    = bsf_pkg::SAMPLE_W + FRACTION_BITS;
  localparam int SEL_W = $clog2(MAX_PASSES + 1);

  logic [bsf_pkg::PASS_W-1:0] pass_count_r;
  logic                       ratio_mode_r;
  logic                       cfg_wr, clear;

  logic [SEL_W-1:0] sel;
  logic             adv, consume, in_accept, out_free;
  logic             drain_r, short_r;
  logic [1:0]       scount_r;

  bsf_pkg::tok_ctl_t    tap_ctl  [MAX_PASSES+1];
  logic signed [DW-1:0] tap_data [MAX_PASSES+1];
  bsf_pkg::tok_ctl_t    in_ctl_nxt;
  bsf_pkg::tok_ctl_t    tok_ctl;
  logic signed [DW-1:0] tok_data, sm_val, raw_scaled;
  logic signed [bsf_pkg::SAMPLE_W-1:0] raw_head;

  logic               div_idle, div_res_valid, div_take;
  bsf_pkg::out_word_t div_res;
  logic               out_valid_r;
  bsf_pkg::out_word_t out_word_r;

  // configuration
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign clear     = cfg_wr && (cfg_index == bsf_pkg::REG_PASS_COUNT ||
                                cfg_index == bsf_pkg::REG_RATIO_MODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_count_r <= bsf_pkg::PASS_COUNT_RST;
      ratio_mode_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        bsf_pkg::REG_PASS_COUNT: pass_count_r <= cfg_data[bsf_pkg::PASS_W-1:0];
        bsf_pkg::REG_RATIO_MODE: ratio_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign sel = (pass_count_r > bsf_pkg::PASS_W'(MAX_PASSES)) ?
               SEL_W'(MAX_PASSES) : pass_count_r[SEL_W-1:0];

  // whole row steps together whenever the sink can take a word (in ratio mode, whenever the divider is idle)
  assign out_free  = !out_valid_r || out_ready;
  assign adv       = ratio_mode_r ? div_idle : out_free;
  assign in_ready  = adv && !drain_r;
  assign in_accept = in_valid && in_ready;

  always_comb begin
    in_ctl_nxt.valid = in_accept;
    in_ctl_nxt.last  = in_word.last_sample;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      tap_ctl[0] <= '0;
    end else if (adv) begin
      tap_ctl[0] <= in_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tap_data[0] <= {in_word.sample, {FRACTION_BITS{1'b0}}};
    end
  end

  for (genvar k = 0; k < MAX_PASSES; k++) begin : g_cell
    bsf_cell #(
      .DW (DW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .clear    (clear),
      .adv      (adv),
      .in_ctl   (tap_ctl[k]),
      .in_data  (tap_data[k]),
      .out_ctl  (tap_ctl[k+1]),
      .out_data (tap_data[k+1])
    );
  end

  assign tok_ctl  = tap_ctl[sel];
  assign tok_data = tap_data[sel];
  assign consume  = adv && tok_ctl.valid;

  // up to one sample held per cell plus one word per tap register
  bsf_raw_fifo #(
    .DEPTH (2 * MAX_PASSES + 2)
  ) u_raw_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (clear),
    .push      (in_accept),
    .push_data (in_word.sample),
    .pop       (consume),
    .head      (raw_head)
  );

  assign raw_scaled = {raw_head, {FRACTION_BITS{1'b0}}};
  assign sm_val     = short_r ? raw_scaled : tok_data;

  // vector bookkeeping: hold off input while a vector flushes
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      drain_r  <= 1'b0;
      short_r  <= 1'b0;
      scount_r <= 2'd0;
    end else begin
      if (in_accept) begin
        if (in_word.last_sample) begin
          drain_r  <= 1'b1;
          short_r  <= (sel != '0) && (scount_r != 2'd2);
          scount_r <= 2'd0;
        end else if (scount_r != 2'd2) begin
          scount_r <= scount_r + 1'b1;
        end
      end else if (consume && tok_ctl.last) begin
        drain_r <= 1'b0;
        short_r <= 1'b0;
      end
    end
  end

  bsf_div #(
    .FB (FRACTION_BITS),
    .DW (DW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (consume && ratio_mode_r),
    .raw       (raw_head),
    .sm        (sm_val),
    .last      (tok_ctl.last),
    .take      (div_take),
    .idle      (div_idle),
    .res_valid (div_res_valid),
    .res       (div_res)
  );

  assign div_take = div_res_valid && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      out_valid_r <= 1'b0;
    end else if ((consume && !ratio_mode_r) || div_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && !ratio_mode_r) begin
      out_word_r.value      <= bsf_pkg::VALUE_W'(sm_val);
      out_word_r.last_value <= tok_ctl.last;
    end else if (div_take) begin
      out_word_r <= div_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

@@ rtl/bsf_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsf_cell
// One 1-2-1 smoothing pass. Holds the previous and current sample of the
// vector and emits the smoothed sample one word behind its input; the last
// word of a vector is followed by the edge word once the row advances again.
// ----------------------------------------------------------------------------
module bsf_cell #(
  parameter int DW = 40
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clear,
  input  logic                 adv,
  input  bsf_pkg::tok_ctl_t    in_ctl,
  input  logic signed [DW-1:0] in_data,
  output bsf_pkg::tok_ctl_t    out_ctl,
  output logic signed [DW-1:0] out_data
);

  logic [1:0]           cnt_r, cnt_nxt;
  logic                 pend_r, pend_nxt;
  logic signed [DW-1:0] prev_r, prev_nxt;
  logic signed [DW-1:0] cur_r, cur_nxt;
  bsf_pkg::tok_ctl_t    out_ctl_r, out_ctl_nxt;
  logic signed [DW-1:0] out_data_r, out_data_nxt;

  logic signed [DW+1:0] term_b, term_c, sum;
  logic signed [DW-1:0] qtr;

  // sum = 2*cur + b + c, then floor divide by four
  always_comb begin
    if (pend_r) begin
      term_b = (DW+2)'(cur_r);
      term_c = (DW+2)'(prev_r);
    end else if (cnt_r == 2'd1) begin
      term_b = (DW+2)'(cur_r);
      term_c = (DW+2)'(in_data);
    end else begin
      term_b = (DW+2)'(prev_r);
      term_c = (DW+2)'(in_data);
    end
    sum = ((DW+2)'(cur_r) <<< 1) + term_b + term_c;
    qtr = sum[DW+1:2];
  end

  always_comb begin
    cnt_nxt      = cnt_r;
    pend_nxt     = pend_r;
    prev_nxt     = prev_r;
    cur_nxt      = cur_r;
    out_ctl_nxt  = out_ctl_r;
    out_data_nxt = out_data_r;
    if (adv) begin
      out_ctl_nxt = '0;
      if (pend_r) begin
        // edge word closes the vector
        out_ctl_nxt.valid = 1'b1;
        out_ctl_nxt.last  = 1'b1;
        out_data_nxt      = (cnt_r == 2'd1) ? cur_r : qtr;
        cnt_nxt           = 2'd0;
        pend_nxt          = 1'b0;
      end else if (in_ctl.valid) begin
        if (cnt_r != 2'd0) begin
          out_ctl_nxt.valid = 1'b1;
          out_data_nxt      = qtr;
          cnt_nxt           = 2'd2;
        end else begin
          cnt_nxt = 2'd1;
        end
        prev_nxt = cur_r;
        cur_nxt  = in_data;
        pend_nxt = in_ctl.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      cnt_r     <= 2'd0;
      pend_r    <= 1'b0;
      out_ctl_r <= '0;
    end else begin
      cnt_r     <= cnt_nxt;
      pend_r    <= pend_nxt;
      out_ctl_r <= out_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_ctl  = out_ctl_r;
  assign out_data = out_data_r;

endmodule

@@ rtl/bsf_raw_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsf_raw_fifo
// Ring buffer of raw samples waiting for their filtered word.
// ----------------------------------------------------------------------------
module bsf_raw_fifo #(
  parameter int DEPTH = 10
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  clear,
  input  logic                                  push,
  input  logic signed [bsf_pkg::SAMPLE_W-1:0]   push_data,
  input  logic                                  pop,
  output logic signed [bsf_pkg::SAMPLE_W-1:0]   head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  logic signed [bsf_pkg::SAMPLE_W-1:0] mem_r [DEPTH];
  logic [AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;

  always_comb begin
    wr_nxt = wr_r;
    rd_nxt = rd_r;
    if (push) begin
      wr_nxt = (wr_r == LAST_IDX) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == LAST_IDX) ? '0 : rd_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      wr_r <= '0;
      rd_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  assign head = mem_r[rd_r];

endmodule

@@ rtl/bsf_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsf_div
// Bit-serial ratio unit: |sample| * 2^(2*FB) / |smoothed|, one quotient bit
// per cycle, truncated toward zero and saturated to the output range.
// ----------------------------------------------------------------------------
module bsf_div #(
  parameter int FB = 16,
  parameter int DW = 40
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [bsf_pkg::SAMPLE_W-1:0] raw,
  input  logic signed [DW-1:0]                sm,
  input  logic                                last,
  input  logic                                take,
  output logic                                idle,
  output logic                                res_valid,
  output bsf_pkg::out_word_t                  res
);

  localparam int NW = bsf_pkg::SAMPLE_W + 2 * FB;
  localparam int CW = $clog2(NW + 1);
  localparam int VW = bsf_pkg::VALUE_W;
  localparam logic [NW-1:0] POS_LIM = NW'((64'd1 << (VW - 1)) - 64'd1);
  localparam logic [NW-1:0] NEG_LIM = NW'(64'd1 << (VW - 1));

  bsf_pkg::div_state_t state_r, state_nxt;
  logic [NW-1:0] num_r, num_nxt, quo_r, quo_nxt;
  logic [DW-1:0] den_r, den_nxt, rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          neg_r, neg_nxt, last_r, last_nxt;
  bsf_pkg::out_word_t res_r, res_nxt;

  logic [bsf_pkg::SAMPLE_W-1:0] raw_mag;
  logic [DW-1:0]                sm_mag;
  logic [DW:0]                  rem_sh, rem_diff;
  logic [NW-1:0]                lim, q_sat;

  always_comb begin
    raw_mag  = raw[bsf_pkg::SAMPLE_W-1] ? bsf_pkg::SAMPLE_W'(-raw) : raw;
    sm_mag   = sm[DW-1] ? DW'(-sm) : sm;
    rem_sh   = {rem_r, num_r[NW-1]};
    rem_diff = rem_sh - {1'b0, den_r};
    lim      = neg_r ? NEG_LIM : POS_LIM;
    q_sat    = (quo_r > lim) ? lim : quo_r;
  end

  always_comb begin
    state_nxt = state_r;
    num_nxt   = num_r;
    quo_nxt   = quo_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    last_nxt  = last_r;
    res_nxt   = res_r;
    unique case (state_r)
      bsf_pkg::DV_IDLE: begin
        if (start) begin
          num_nxt  = {raw_mag, {(2 * FB){1'b0}}};
          den_nxt  = sm_mag;
          rem_nxt  = '0;
          quo_nxt  = '0;
          cnt_nxt  = CW'(NW);
          neg_nxt  = raw[bsf_pkg::SAMPLE_W-1] != sm[DW-1];
          last_nxt = last;
          // zero divisor gives zero
          state_nxt = (sm == '0) ? bsf_pkg::DV_FIN : bsf_pkg::DV_RUN;
        end
      end
      bsf_pkg::DV_RUN: begin
        num_nxt = num_r << 1;
        if (!rem_diff[DW]) begin
          rem_nxt = rem_diff[DW-1:0];
          quo_nxt = {quo_r[NW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[DW-1:0];
          quo_nxt = {quo_r[NW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          state_nxt = bsf_pkg::DV_FIN;
        end
      end
      bsf_pkg::DV_FIN: begin
        res_nxt.value      = neg_r ? -VW'(q_sat) : VW'(q_sat);
        res_nxt.last_value = last_r;
        state_nxt          = bsf_pkg::DV_DONE;
      end
      bsf_pkg::DV_DONE: begin
        if (take) begin
          state_nxt = bsf_pkg::DV_IDLE;
        end
      end
      default: state_nxt = bsf_pkg::DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsf_pkg::DV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    quo_r  <= quo_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    neg_r  <= neg_nxt;
    last_r <= last_nxt;
    res_r  <= res_nxt;
  end

  assign idle      = state_r == bsf_pkg::DV_IDLE;
  assign res_valid = state_r == bsf_pkg::DV_DONE;
  assign res       = res_r;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives vectors of signed samples through the binomial smoothing filter
// under several pass counts in both output modes, with random gaps on the
// input and random stalls on the output, and checks every output word
// against a cycle-free model of the smoothing and ratio arithmetic.
// ----------------------------------------------------------------------------
module testbench;

  localparam int PASS_LIMIT = 8;
  localparam int FRAC = 16;
  localparam int DELAY_DEPTH = PASS_LIMIT + 2;
  localparam longint unsigned POS_SAT = (64'd1 << 47) - 1;
  localparam longint unsigned NEG_SAT = 64'd1 << 47;
  localparam logic [bsf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 4'd5;
  localparam int CYCLE_LIMIT = 600000;

  class smoothing_scoreboard;
    int unsigned pass_cnt;
    bit ratio_on;
    longint held_prev[PASS_LIMIT];
    longint held_cur[PASS_LIMIT];
    int seen[PASS_LIMIT];
    int raw_q[$];
    bsf_pkg::out_word_t expected_words[$];
    int errors;

    function void clear_vector();
      for (int k = 0; k < PASS_LIMIT; k++) begin
        held_prev[k] = 0;
        held_cur[k] = 0;
        seen[k] = 0;
      end
      raw_q.delete();
    endfunction

    function void reset_state();
      pass_cnt = bsf_pkg::PASS_COUNT_RST;
      ratio_on = 0;
      errors = 0;
      clear_vector();
    endfunction

    function void configure(logic [bsf_pkg::CFG_IDX_W-1:0] idx,
                            logic [bsf_pkg::CFG_DATA_W-1:0] data);
      if (idx == bsf_pkg::REG_PASS_COUNT) begin
        pass_cnt = data;
        clear_vector();
      end else if (idx == bsf_pkg::REG_RATIO_MODE) begin
        ratio_on = data[0];
        clear_vector();
      end
    endfunction

    // one three-tap pass; returns the number of values it releases
    function int pass_step(int k, longint x, bit lst, output longint o0, output longint o1);
      int n;
      n = 0;
      o0 = 0;
      o1 = 0;
      if (seen[k] == 0) begin
        if (lst) begin
          o0 = x;
          n = 1;
        end else begin
          held_cur[k] = x;
          seen[k] = 1;
        end
        return n;
      end
      if (seen[k] == 1) o0 = (3 * held_cur[k] + x) >>> 2;
      else o0 = (2 * held_cur[k] + held_prev[k] + x) >>> 2;
      n = 1;
      if (lst) begin
        o1 = (3 * x + held_cur[k]) >>> 2;
        n = 2;
        seen[k] = 0;
      end else begin
        held_prev[k] = held_cur[k];
        held_cur[k] = x;
        seen[k] = 2;
      end
      return n;
    endfunction

    function longint ratio_of(int s, longint sm);
      longint unsigned num, den, q, r, lim;
      bit neg;
      if (sm == 0) return 0;
      neg = (s < 0) != (sm < 0);
      num = longint'(s < 0 ? -longint'(s) : longint'(s)) << FRAC;
      den = sm < 0 ? -sm : sm;
      lim = neg ? NEG_SAT : POS_SAT;
      q = num / den;
      r = num % den;
      for (int i = 0; i < FRAC && q <= NEG_SAT; i++) begin
        q = q << 1;
        r = r << 1;
        if (r >= den) begin
          r = r - den;
          q = q + 1;
        end
      end
      if (q > lim) q = lim;
      return neg ? -longint'(q) : longint'(q);
    endfunction

    function void note_input(bsf_pkg::in_word_t w);
      longint cur_list[$];
      longint nxt_list[$];
      longint o0, o1, v;
      int passes, s, rs, c, m;
      bit short_vec;
      bsf_pkg::out_word_t ew;
      s = int'(w.sample);
      passes = (pass_cnt > PASS_LIMIT) ? PASS_LIMIT : pass_cnt;
      short_vec = passes >= 1 && w.last_sample && seen[0] < 2;
      if (raw_q.size() < DELAY_DEPTH) raw_q.push_back(s);
      else raw_q[DELAY_DEPTH-1] = s;
      cur_list.push_back(longint'(s) * (64'sd1 << FRAC));
      for (int k = 0; k < passes; k++) begin
        nxt_list.delete();
        m = cur_list.size();
        for (int i = 0; i < m; i++) begin
          c = pass_step(k, cur_list[i], w.last_sample && i == m - 1, o0, o1);
          if (c > 0) nxt_list.push_back(o0);
          if (c > 1) nxt_list.push_back(o1);
        end
        cur_list = nxt_list;
      end
      m = cur_list.size();
      for (int e = 0; e < m; e++) begin
        rs = raw_q.size() ? raw_q.pop_front() : 0;
        v = short_vec ? longint'(rs) * (64'sd1 << FRAC) : cur_list[e];
        if (ratio_on) v = ratio_of(rs, v);
        ew.value = v[bsf_pkg::VALUE_W-1:0];
        ew.last_value = w.last_sample && e == m - 1;
        expected_words.push_back(ew);
      end
      if (w.last_sample) raw_q.delete();
    endfunction

    function void check_result(bsf_pkg::out_word_t got);
      bsf_pkg::out_word_t ew;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word value=%0d last=%0b", $time, got.value,
                 got.last_value);
        errors++;
        return;
      end
      ew = expected_words.pop_front();
      if (got.value !== ew.value) begin
        $display("%0t: value mismatch expected=%0d actual=%0d", $time, ew.value,
                 got.value);
        errors++;
      end
      if (got.last_value !== ew.last_value) begin
        $display("%0t: last mismatch expected=%0b actual=%0b", $time,
                 ew.last_value, got.last_value);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  bsf_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_ready = 0;
  bsf_pkg::out_word_t out_word;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [bsf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bsf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  smoothing_scoreboard sb;
  int unsigned cycle_cnt = 0;
  bit quiet = 0;
  int stall_left = 0;
  int items_sent = 0;

  binomial_smoothing_filter u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // output stalls, checking on every accepted word
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (rst_n && out_valid && out_ready) sb.check_result(out_word);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 0;
    end else begin
      stall_left <= pick_gap();
      out_ready <= 1;
    end
  end

  task automatic send_word(logic signed [bsf_pkg::SAMPLE_W-1:0] smp, logic lst);
    int gap;
    in_valid <= 1;
    in_word <= '{sample: smp, last_sample: lst};
    do @(posedge clk); while (!in_ready);
    sb.note_input('{sample: smp, last_sample: lst});
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_vector(int len, int kind);
    logic signed [bsf_pkg::SAMPLE_W-1:0] smp;
    for (int i = 0; i < len; i++) begin
      case (kind)
        0: smp = bsf_pkg::SAMPLE_W'($urandom);
        1: smp = bsf_pkg::SAMPLE_W'(int'($urandom_range(0, 6)) - 3);
        default: smp = ($urandom_range(0, 3) == 0) ?
                       bsf_pkg::SAMPLE_W'($urandom) :
                       bsf_pkg::SAMPLE_W'(int'($urandom_range(0, 4)) - 2);
      endcase
      send_word(smp, i == len - 1);
    end
  endtask

  task automatic send_list(logic signed [bsf_pkg::SAMPLE_W-1:0] vals[$]);
    foreach (vals[i]) send_word(vals[i], i == vals.size() - 1);
  endtask

  task automatic write_reg(logic [bsf_pkg::CFG_IDX_W-1:0] idx,
                           logic [bsf_pkg::CFG_DATA_W-1:0] data);
    in_valid <= 0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.configure(idx, data);
  endtask

  task automatic random_phase(int n_items);
    int target, len;
    target = items_sent + n_items;
    while (items_sent < target) begin
      quiet = ($urandom_range(0, 5) == 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 14);
      send_vector(len, $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 2));
    end
    quiet = 0;
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // default pass count: lone samples, pairs and extremes
    send_list('{24'sh7fffff});
    send_list('{24'sh800000, 24'sh7fffff});
    send_list('{24'sh7fffff, 24'sh800000, 24'sh7fffff, 24'sh000000});
    send_list('{24'sh000000, 24'shffffff, 24'sh000001});
    random_phase(40);

    write_reg(bsf_pkg::REG_PASS_COUNT, 4'd0);
    send_list('{24'sh800000});
    random_phase(30);

    // above the pass limit saturates
    write_reg(bsf_pkg::REG_PASS_COUNT, 4'd15);
    send_list('{24'sh800000, 24'sh7fffff, 24'sh800000, 24'sh7fffff, 24'sh800000});
    send_list('{24'sh123456, 24'sh800000});
    random_phase(50);

    write_reg(REG_UNUSED, 4'd9);
    write_reg(bsf_pkg::REG_PASS_COUNT, 4'd8);
    random_phase(40);

    // ratio mode: zero smoothed values, pass-through and overflow
    write_reg(bsf_pkg::REG_RATIO_MODE, 4'd1);
    send_list('{24'sh000000, 24'sh000000, 24'sh000000});
    send_list('{24'sh7fffff, 24'shffffff, 24'sh000001, 24'shffffff, 24'sh000001});
    send_list('{24'sh800000, 24'sh000001});
    random_phase(70);

    write_reg(bsf_pkg::REG_PASS_COUNT, 4'd0);
    send_list('{24'sh800000, 24'sh7fffff, 24'sh000000});
    random_phase(30);

    write_reg(bsf_pkg::REG_PASS_COUNT, 4'd3);
    random_phase(60);

    write_reg(bsf_pkg::REG_RATIO_MODE, 4'd14);
    write_reg(bsf_pkg::REG_PASS_COUNT, 4'd2);
    random_phase(90);

    in_valid <= 0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
